[rtl/swm_pkg.sv]
// Shared types and constants for the sliding window mean/deviation/median block.
// Depends on nothing; swm_div and the top level refer to it by scoped names.
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int TIME_WIDTH   = 32;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_value;
        logic        [TIME_WIDTH-1:0]   sample_time;
    } t_in;

    typedef struct packed {
        logic        [TIME_WIDTH-1:0]   center_time;
        logic signed [SAMPLE_WIDTH-1:0] window_mean;
        logic        [SAMPLE_WIDTH-1:0] window_deviation;
        logic signed [SAMPLE_WIDTH-1:0] window_median;
    } t_out;

    // Command to the shared constant divider.
    typedef struct packed {
        logic start;
        logic narrow;   // dividend holds only the low narrow-width bits
    } t_div_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MSTART,
        ST_MWAIT,
        ST_VAR,
        ST_VSTART,
        ST_VWAIT,
        ST_ROOT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/swm_div.sv]
// Divider by a constant: one 16-bit quotient digit per cycle by reciprocal multiply.
// Depends on swm_pkg for the command struct.
`default_nettype none

module swm_div #(
    parameter int DIVISOR  = 5,
    parameter int DIV_W    = 52,
    parameter int NARROW_W = 27
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  swm_pkg::t_div_cmd      i_cmd,
    input  wire  [DIV_W-1:0]       i_dividend,
    output logic [DIV_W-1:0]       o_quotient,
    output logic                   o_done
);

    localparam int DIG_W    = 16;
    localparam int SHIFT    = 24;
    localparam int REM_W    = $clog2(DIVISOR);
    localparam int X_W      = REM_W + DIG_W;
    localparam int P_W      = SHIFT + DIG_W;
    localparam int WIDE_D   = (DIV_W + DIG_W - 1) / DIG_W;
    localparam int NARROW_D = (NARROW_W + DIG_W - 1) / DIG_W;
    localparam int ACC_W    = WIDE_D * DIG_W;
    localparam int CNT_W    = $clog2(WIDE_D + 1);
    // Reciprocal rounded up; exact floor for any partial dividend below DIVISOR << DIG_W.
    localparam logic [SHIFT-1:0] RECIP = SHIFT'(((longint'(1) << SHIFT)
        + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR));
    localparam logic [X_W-1:0] DIV_K = X_W'(DIVISOR);

    logic [ACC_W-1:0] r_acc;
    logic [REM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [X_W-1:0]   w_x;
    logic [P_W-1:0]   w_prod;
    logic [DIG_W-1:0] w_qd;
    logic [X_W-1:0]   w_back;
    logic [X_W-1:0]   w_left;

    assign w_x    = {r_rem, r_acc[ACC_W-1 -: DIG_W]};
    assign w_prod = P_W'(w_x) * P_W'(RECIP);
    assign w_qd   = w_prod[SHIFT +: DIG_W];
    assign w_back = X_W'(w_qd) * DIV_K;
    assign w_left = w_x - w_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_cmd.start) begin
                r_cnt <= i_cmd.narrow ? CNT_W'(NARROW_D) : CNT_W'(WIDE_D);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Top-align a narrow dividend so the quotient lands in the low digits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= '0;
            r_acc <= i_cmd.narrow ? (ACC_W'(i_dividend) << (ACC_W - NARROW_D * DIG_W))
                                  : ACC_W'(i_dividend);
        end else if (r_cnt != '0) begin
            r_rem <= w_left[REM_W-1:0];
            r_acc <= {r_acc[ACC_W-DIG_W-1:0], w_qd};
        end
    end

    assign o_quotient = r_acc[DIV_W-1:0];
    assign o_done     = r_done;

endmodule

`default_nettype wire

[rtl/swm_sqrt.sv]
// Iterative floor square root: one root bit per cycle, digit by digit.
// Depends on nothing beyond its ports.
`default_nettype none

module swm_sqrt #(
    parameter int RT_W = 24
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire  [2*RT_W-1:0]     i_radicand,
    output logic [RT_W-1:0]       o_root,
    output logic                  o_done
);

    localparam int REM_W = RT_W + 2;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic [2*RT_W-1:0] r_x;
    logic [REM_W-1:0]  r_rem;
    logic [RT_W-1:0]   r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;

    logic [REM_W+1:0]  w_rem_in;
    logic [REM_W+1:0]  w_trial;
    logic              w_ge;
    logic [REM_W+1:0]  w_diff;

    assign w_rem_in = {r_rem, r_x[2*RT_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_ge     = (w_rem_in >= w_trial);
    assign w_diff   = w_rem_in - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(RT_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Bring down two radicand bits, try root*4+1, keep the remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_x    <= {r_x[2*RT_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_rem_in[REM_W-1:0];
            r_root <= {r_root[RT_W-2:0], w_ge};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

`default_nettype wire

[rtl/sliding_window_mean_std_median_top.sv]
// Top level of the sliding window mean, deviation and median block.
// Depends on swm_pkg, swm_div (shared constant divider) and swm_sqrt.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-------------------------
//   in      | into      | i_in_valid / o_in_ready | swm_pkg::t_in  (sample)
//   out     | out of    | o_out_valid/i_out_ready | swm_pkg::t_out (result)
//
// Flow: a sample that only fills the window is taken in ST_IDLE, and the
//   block stays ready for the next one. Once the window is full a sample
//   starts a sum/rank pass over the window, a divide of the sum (2 16-bit
//   divider digits for N = 5), a square pass, a divide of the square sum
//   (4 16-bit divider digits), then the square root.
//   The square root, one root bit per cycle, is the longest of these steps.
// Reset: synchronous, active low; clears the sequencer, fill count and the
//   output valid. The window contents are don't-care until it is full.
// Stalls: the result sits in an output register, so a new sample is taken
//   while the previous result waits; a finished result waits in ST_DONE only
//   while the output register is still full.
`default_nettype none

module sliding_window_mean_std_median_top #(
    parameter int WINDOW_SIZE = 5
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  swm_pkg::t_in        i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output swm_pkg::t_out       o_out_data
);

    localparam int SW     = swm_pkg::SAMPLE_WIDTH;
    localparam int TW     = swm_pkg::TIME_WIDTH;
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int IX_W   = $clog2(WINDOW_SIZE);
    localparam int SUM_W  = SW + $clog2(WINDOW_SIZE);
    localparam int SQ_W   = 2 * SW + $clog2(WINDOW_SIZE);
    localparam int MID    = WINDOW_SIZE / 2;
    localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(WINDOW_SIZE);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WINDOW_SIZE - 1);
    localparam logic [CNT_W-1:0] MID_CNT  = CNT_W'(MID);

    // Window: oldest at index 0, newest at WINDOW_SIZE-1.
    logic signed [SW-1:0] r_win  [WINDOW_SIZE];
    logic        [TW-1:0] r_time [WINDOW_SIZE];

    swm_pkg::t_state      r_state, n_state;
    logic [CNT_W-1:0]     r_fill;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SW-1:0] r_mean;
    logic signed [SW-1:0] r_median;
    logic [2*SW-1:0]      r_prod;
    logic [SQ_W-1:0]      r_sq;
    logic                 r_out_valid;
    swm_pkg::t_out        r_out;

    logic                 w_in_fire;
    logic                 w_out_load;
    logic [IX_W-1:0]      w_idx;
    logic signed [SW-1:0] w_cand;
    logic [CNT_W-1:0]     w_less;
    logic [CNT_W-1:0]     w_leq;
    logic [SUM_W-1:0]     w_sum_mag;
    logic [SW-1:0]        w_q_mean;
    logic signed [SW:0]   w_dev;
    logic [SW:0]          w_dev_mag;

    swm_pkg::t_div_cmd    w_div_cmd;
    logic [SQ_W-1:0]      w_div_in;
    logic [SQ_W-1:0]      w_div_q;
    logic                 w_div_done;
    logic                 w_sqrt_start;
    logic [SW-1:0]        w_root;
    logic                 w_sqrt_done;

    assign o_in_ready = (r_state == swm_pkg::ST_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == swm_pkg::ST_DONE) && (!r_out_valid || i_out_ready);

    assign w_idx  = r_cnt[IX_W-1:0];
    assign w_cand = r_win[w_idx];

    // Rank of the current candidate: counts of smaller and not-larger entries.
    always_comb begin
        w_less = '0;
        w_leq  = '0;
        for (int j = 0; j < WINDOW_SIZE; j++) begin
            w_less = w_less + CNT_W'(r_win[j] <  w_cand);
            w_leq  = w_leq  + CNT_W'(r_win[j] <= w_cand);
        end
    end

    assign w_sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_q_mean  = w_div_q[SW-1:0];
    assign w_dev     = (SW + 1)'(w_cand) - (SW + 1)'(r_mean);
    assign w_dev_mag = w_dev[SW] ? (SW + 1)'(-w_dev) : (SW + 1)'(w_dev);

    assign w_div_in = (r_state == swm_pkg::ST_MSTART) ? SQ_W'(w_sum_mag) : r_sq;

    swm_div #(
        .DIVISOR  (WINDOW_SIZE),
        .DIV_W    (SQ_W),
        .NARROW_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_div_cmd),
        .i_dividend (w_div_in),
        .o_quotient (w_div_q),
        .o_done     (w_div_done)
    );

    swm_sqrt #(
        .RT_W (SW)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_div_q[2*SW-1:0]),
        .o_root     (w_root),
        .o_done     (w_sqrt_done)
    );

    // Sequencer: next state, counter and unit commands.
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        w_div_cmd    = '0;
        w_sqrt_start = 1'b0;
        unique case (r_state)
            swm_pkg::ST_IDLE: begin
                n_cnt = '0;
                // Start work once this sample completes the window.
                if (w_in_fire && (r_fill == N_CNT || r_fill == LAST_CNT)) begin
                    n_state = swm_pkg::ST_SUM;
                end
            end
            swm_pkg::ST_SUM: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == LAST_CNT) begin
                    n_state = swm_pkg::ST_MSTART;
                end
            end
            swm_pkg::ST_MSTART: begin
                n_cnt            = '0;
                w_div_cmd.start  = 1'b1;
                w_div_cmd.narrow = 1'b1;
                n_state          = swm_pkg::ST_MWAIT;
            end
            swm_pkg::ST_MWAIT: begin
                if (w_div_done) begin
                    n_state = swm_pkg::ST_VAR;
                end
            end
            swm_pkg::ST_VAR: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == N_CNT) begin
                    n_state = swm_pkg::ST_VSTART;
                end
            end
            swm_pkg::ST_VSTART: begin
                w_div_cmd.start = 1'b1;
                n_state         = swm_pkg::ST_VWAIT;
            end
            swm_pkg::ST_VWAIT: begin
                if (w_div_done) begin
                    w_sqrt_start = 1'b1;
                    n_state      = swm_pkg::ST_ROOT;
                end
            end
            swm_pkg::ST_ROOT: begin
                if (w_sqrt_done) begin
                    n_state = swm_pkg::ST_DONE;
                end
            end
            swm_pkg::ST_DONE: begin
                if (w_out_load) begin
                    n_state = swm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swm_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            // Saturate the fill count at the window size.
            if (w_in_fire && r_fill != N_CNT) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        // Shift the window by one on every accepted sample.
        if (w_in_fire) begin
            for (int k = 0; k < WINDOW_SIZE - 1; k++) begin
                r_win[k]  <= r_win[k+1];
                r_time[k] <= r_time[k+1];
            end
            r_win[WINDOW_SIZE-1]  <= i_in_data.sample_value;
            r_time[WINDOW_SIZE-1] <= i_in_data.sample_time;
        end

        case (r_state)
            swm_pkg::ST_IDLE: begin
                r_sum <= '0;
            end
            swm_pkg::ST_SUM: begin
                r_sum <= r_sum + SUM_W'(w_cand);
                // Candidate sits at the middle rank: keep it as the median.
                if (w_less <= MID_CNT && w_leq > MID_CNT) begin
                    r_median <= w_cand;
                end
            end
            swm_pkg::ST_MWAIT: begin
                if (w_div_done) begin
                    r_mean <= r_sum[SUM_W-1] ? SW'(-w_q_mean) : SW'(w_q_mean);
                    r_sq   <= '0;
                end
            end
            swm_pkg::ST_VAR: begin
                // Square one deviation per cycle, accumulate it the next.
                if (r_cnt != N_CNT) begin
                    r_prod <= w_dev_mag[SW-1:0] * w_dev_mag[SW-1:0];
                end
                if (r_cnt != '0) begin
                    r_sq <= r_sq + SQ_W'(r_prod);
                end
            end
            swm_pkg::ST_DONE: begin
                if (w_out_load) begin
                    r_out.center_time      <= r_time[MID];
                    r_out.window_mean      <= r_mean;
                    r_out.window_deviation <= w_root;
                    r_out.window_median    <= r_median;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
